FILE: design/otseq_pkg.sv
package otseq_pkg;

  localparam logic [7:0] CmdSkipRom     = 8'hCC;
  localparam logic [7:0] CmdConvert     = 8'h44;
  localparam logic [7:0] CmdReadScratch = 8'hBE;
  localparam int unsigned ScratchBits   = 72;
  localparam logic [3:0] ScratchBytes   = 4'(ScratchBits / 8);
  localparam logic [3:0] NibbleMask     = 4'h0F;
  localparam logic [7:0] CrcPoly        = 8'h8C;

  typedef enum logic [2:0] {
    EV_START = 3'd0,
    EV_RESET = 3'd1,
    EV_WDONE = 3'd2,
    EV_BIT   = 3'd3,
    EV_BYTE  = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    LC_NONE  = 3'd0,
    LC_RESET = 3'd1,
    LC_WRITE = 3'd2,
    LC_RBIT  = 3'd3,
    LC_RBYTE = 3'd4
  } link_cmd_t;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_DONE   = 2'd1,
    ST_NOPRES = 2'd2,
    ST_CRCERR = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_CONV_RESET = 4'd1,
    PH_CONV_SKIP  = 4'd2,
    PH_CONV_CMD   = 4'd3,
    PH_POLL       = 4'd4,
    PH_RD_RESET   = 4'd5,
    PH_RD_SKIP    = 4'd6,
    PH_RD_CMD     = 4'd7,
    PH_RD_DATA    = 4'd8
  } phase_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       presence;
    logic       rx_bit;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]        link_cmd;
    logic [7:0]        tx_byte;
    logic [1:0]        status;
    logic signed [11:0] temperature;
  } result_t;

endpackage

FILE: design/otseq_crc.sv
module otseq_crc (
  input  logic [7:0] crc,
  input  logic [7:0] data,
  output logic [7:0] crc_next
);

  // Maxim CRC-8 over one byte, least significant bit first.
  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = data;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ d[0]) begin
        c = (c >> 1) ^ otseq_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    crc_next = c;
  end

endmodule

FILE: design/otseq_fsm.sv
module otseq_fsm (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  otseq_pkg::item_t   item,
  output otseq_pkg::result_t result
);

  otseq_pkg::phase_t phase, phase_next;
  logic [3:0] byte_index, byte_index_next;
  logic [7:0] crc_reg, crc_reg_next;
  logic [7:0] temp_low_byte, temp_low_byte_next;
  logic [3:0] temp_high_nibble, temp_high_nibble_next;
  logic [7:0] crc_upd;
  logic [3:0] index_inc;

  otseq_crc u_crc (
    .crc      (crc_reg),
    .data     (item.rx_byte),
    .crc_next (crc_upd)
  );

  assign index_inc = byte_index + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= otseq_pkg::PH_IDLE;
      byte_index       <= '0;
      crc_reg          <= '0;
      temp_low_byte    <= '0;
      temp_high_nibble <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      byte_index       <= byte_index_next;
      crc_reg          <= crc_reg_next;
      temp_low_byte    <= temp_low_byte_next;
      temp_high_nibble <= temp_high_nibble_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    byte_index_next       = byte_index;
    crc_reg_next          = crc_reg;
    temp_low_byte_next    = temp_low_byte;
    temp_high_nibble_next = temp_high_nibble;
    result.link_cmd       = otseq_pkg::LC_NONE;
    result.tx_byte        = '0;
    result.status         = otseq_pkg::ST_BUSY;
    result.temperature    = '0;
    case (phase)
      otseq_pkg::PH_IDLE: begin
        if (item.req_type == otseq_pkg::EV_START) begin
          result.link_cmd = otseq_pkg::LC_RESET;
          phase_next      = otseq_pkg::PH_CONV_RESET;
        end
      end
      otseq_pkg::PH_CONV_RESET, otseq_pkg::PH_RD_RESET: begin
        if (item.req_type == otseq_pkg::EV_RESET) begin
          if (item.presence) begin
            result.link_cmd = otseq_pkg::LC_WRITE;
            result.tx_byte  = otseq_pkg::CmdSkipRom;
            phase_next      = (phase == otseq_pkg::PH_CONV_RESET) ?
                              otseq_pkg::PH_CONV_SKIP : otseq_pkg::PH_RD_SKIP;
          end else begin
            result.status = otseq_pkg::ST_NOPRES;
            phase_next    = otseq_pkg::PH_IDLE;
          end
        end
      end
      otseq_pkg::PH_CONV_SKIP: begin
        if (item.req_type == otseq_pkg::EV_WDONE) begin
          result.link_cmd = otseq_pkg::LC_WRITE;
          result.tx_byte  = otseq_pkg::CmdConvert;
          phase_next      = otseq_pkg::PH_CONV_CMD;
        end
      end
      otseq_pkg::PH_CONV_CMD: begin
        if (item.req_type == otseq_pkg::EV_WDONE) begin
          result.link_cmd = otseq_pkg::LC_RBIT;
          phase_next      = otseq_pkg::PH_POLL;
        end
      end
      otseq_pkg::PH_POLL: begin
        if (item.req_type == otseq_pkg::EV_BIT) begin
          if (item.rx_bit) begin
            result.link_cmd = otseq_pkg::LC_RESET;
            phase_next      = otseq_pkg::PH_RD_RESET;
          end else begin
            result.link_cmd = otseq_pkg::LC_RBIT;
          end
        end
      end
      otseq_pkg::PH_RD_SKIP: begin
        if (item.req_type == otseq_pkg::EV_WDONE) begin
          result.link_cmd = otseq_pkg::LC_WRITE;
          result.tx_byte  = otseq_pkg::CmdReadScratch;
          phase_next      = otseq_pkg::PH_RD_CMD;
        end
      end
      otseq_pkg::PH_RD_CMD: begin
        if (item.req_type == otseq_pkg::EV_WDONE) begin
          result.link_cmd = otseq_pkg::LC_RBYTE;
          byte_index_next = '0;
          crc_reg_next    = '0;
          phase_next      = otseq_pkg::PH_RD_DATA;
        end
      end
      otseq_pkg::PH_RD_DATA: begin
        if (item.req_type == otseq_pkg::EV_BYTE) begin
          crc_reg_next    = crc_upd;
          byte_index_next = index_inc;
          if (byte_index == 4'd0) begin
            temp_low_byte_next = item.rx_byte;
          end
          if (byte_index == 4'd1) begin
            temp_high_nibble_next = item.rx_byte[3:0] & otseq_pkg::NibbleMask;
          end
          if (index_inc >= otseq_pkg::ScratchBytes) begin
            if (crc_upd == 8'd0) begin
              result.status      = otseq_pkg::ST_DONE;
              result.temperature = {temp_high_nibble, temp_low_byte};
            end else begin
              result.status = otseq_pkg::ST_CRCERR;
            end
            phase_next = otseq_pkg::PH_IDLE;
          end else begin
            result.link_cmd = otseq_pkg::LC_RBYTE;
          end
        end
      end
      default: begin
        phase_next = otseq_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

FILE: design/onewire_thermometer_sequencer_core.sv
// Channel  Direction  tuser           tdata
// s_*      in         req_type [2:0]  presence [0], rx_bit [1], rx_byte [9:2]
// m_*      out        link_cmd [2:0]  tx_byte [7:0], status [9:8], temperature [21:10]
//
// Each beat passes an input register and a result register, and one beat per cycle is
// sustained while m_tready stays high.
// The sequencer state advances when a beat moves from the input register to the
// result register. Reset clears the state to idle and empties both registers.
// While the result waits, a new beat is still taken into an empty input register.
module onewire_thermometer_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // presence, rx_bit, rx_byte, zero fill
  input  logic [2:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // tx_byte, status, temperature, zero fill
  output logic [2:0]  m_tuser    // link_cmd
);

  logic               in_valid;
  otseq_pkg::item_t   in_item;
  logic               out_valid;
  otseq_pkg::result_t out_result;
  otseq_pkg::result_t result;
  logic               advance;
  logic               fire;

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type <= s_tuser;
      in_item.presence <= s_tdata[0];
      in_item.rx_bit   <= s_tdata[1];
      in_item.rx_byte  <= s_tdata[9:2];
    end
  end

  otseq_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_result.link_cmd;
  assign m_tdata  = {2'b00, out_result.temperature, out_result.status, out_result.tx_byte};

`ifndef SYNTHESIS
  a_tx_only_on_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != otseq_pkg::LC_WRITE) |-> m_tdata[7:0] == 8'd0)
    else $error("write byte set without a write command");

  a_temp_only_on_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[9:8] != otseq_pkg::ST_DONE) |-> m_tdata[21:10] == 12'd0)
    else $error("temperature set without done status");

  a_status_ends_sequence: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[9:8] != otseq_pkg::ST_BUSY) |-> m_tuser == otseq_pkg::LC_NONE)
    else $error("link command issued together with a final status");

  a_held_input_while_stalled: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("input register changed while the result register was full");
`endif

endmodule
